### rtl/particle_gravity_bounce_step_defines.svh
// Assertion macros used by the checker file.
`ifndef PARTICLE_GRAVITY_BOUNCE_STEP_DEFINES_SVH
`define PARTICLE_GRAVITY_BOUNCE_STEP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define PGB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define PGB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pgb_pkg.sv
package pgb_pkg;

  localparam int unsigned FracBitsDef = 8;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;

  typedef enum logic [CfgIdxW-1:0] {
    RegGravity       = 3'd0,
    RegFloorLevel    = 3'd1,
    RegBounceGain    = 3'd2,
    RegGlideGain     = 3'd3,
    RegRestThreshold = 3'd4,
    RegRestDamping   = 3'd5,
    RegLowerBound    = 3'd6,
    RegUpperBound    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic        [14:0] gravity;
    logic signed [15:0] floor_level;
    logic        [7:0]  bounce_gain;
    logic        [7:0]  glide_gain;
    logic        [14:0] rest_threshold;
    logic        [7:0]  rest_damping;
    logic signed [15:0] lower_bound;
    logic signed [15:0] upper_bound;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    gravity:        15'd2509,
    floor_level:    16'sd896,
    bounce_gain:    8'd154,
    glide_gain:     8'd205,
    rest_threshold: 15'd77,
    rest_damping:   8'd77,
    lower_bound:    -16'sd1280,
    upper_bound:    16'sd12800
  };

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic signed [15:0] life_left;
    logic        [15:0] step_time;
    logic               active_in;
  } in_t;

  typedef struct packed {
    logic signed [15:0] new_pos_x;
    logic signed [15:0] new_pos_y;
    logic signed [15:0] new_pos_z;
    logic signed [15:0] new_vel_x;
    logic signed [15:0] new_vel_y;
    logic signed [15:0] new_vel_z;
    logic signed [15:0] new_life;
    logic               alive;
  } out_t;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### rtl/pgb_in_if.sv
interface pgb_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] vel_z;
  logic signed [15:0] life_left;
  logic        [15:0] step_time;
  logic               active_in;

  modport source (
    output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, life_left, step_time,
           active_in,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, life_left, step_time,
           active_in,
    output ready
  );

  modport monitor (
    input valid, ready, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, life_left, step_time,
          active_in
  );
endinterface

### rtl/pgb_out_if.sv
interface pgb_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] new_pos_x;
  logic signed [15:0] new_pos_y;
  logic signed [15:0] new_pos_z;
  logic signed [15:0] new_vel_x;
  logic signed [15:0] new_vel_y;
  logic signed [15:0] new_vel_z;
  logic signed [15:0] new_life;
  logic               alive;

  modport source (
    output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
           new_life, alive,
    input  ready
  );

  modport sink (
    input  valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
           new_life, alive,
    output ready
  );

  modport monitor (
    input valid, ready, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
          new_life, alive
  );
endinterface

### rtl/pgb_pipe.sv
module pgb_pipe #(
  parameter int unsigned FRAC_BITS = pgb_pkg::FracBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pgb_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pgb_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pgb_pkg::out_t out_data_o
);
  import pgb_pkg::*;

  localparam int unsigned NumStages = 6;
  localparam int unsigned LifeShift = 16 - FRAC_BITS;
  localparam logic [16:0] LifeHalf  = 17'(1) << (LifeShift - 1);

  typedef struct packed {
    logic signed [15:0] px, py, pz, vx, vy, vz, life;
    logic        [15:0] dt;
    logic        [30:0] gprod;
    logic signed [32:0] xprod, zprod;
    logic               active;
  } s1_t;

  typedef struct packed {
    logic signed [15:0] px, py, pz, vx, vy, vz, life;
    logic        [15:0] dt;
    logic               active;
  } s2_t;

  typedef struct packed {
    logic signed [15:0] px, py, pz, vx, vy, vz, life;
    logic signed [32:0] yprod;
    logic signed [25:0] bprod;
    logic signed [24:0] xg, zg;
    logic               active;
  } s3_t;

  typedef struct packed {
    logic signed [15:0] px, py, pz, vx, vy, vz, life;
    logic               active;
    logic               dmp;
  } s4_t;

  typedef struct packed {
    logic signed [15:0] px, py, pz, vx, vy, vz, life;
    logic signed [24:0] xd, zd;
    logic               dmp;
    logic               alive;
  } s5_t;

  logic [NumStages-1:0] v_q, v_d, en;

  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  s4_t  s4_d, s4_q;
  s5_t  s5_d, s5_q;
  out_t s6_d, s6_q;

  // stage 1 intermediates
  logic        [16:0] lsum, lr;
  // stage 2 intermediates
  logic        [31:0] gsum;
  logic        [15:0] gr;
  logic signed [33:0] xsum2, zsum2;
  logic signed [17:0] xr2, zr2;
  // stage 3 intermediates
  logic signed [16:0] negvy;
  // stage 4 intermediates
  logic signed [32:0] ysum;
  logic signed [16:0] yr;
  logic signed [15:0] py4, vyb, vxb, vzb;
  logic signed [25:0] bsum;
  logic signed [17:0] br;
  logic signed [24:0] xgs, zgs;
  logic signed [16:0] xgr, zgr, vyb_mag;
  logic               on_floor, at_rest;
  // stage 6 intermediates
  logic signed [24:0] xds, zds;
  logic signed [16:0] xdr, zdr;

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d = {v_q[NumStages-2:0], in_valid_i};
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NumStages-1];
  assign out_data_o  = s6_q;

  // stage 1: gravity and horizontal travel products, life countdown
  always_comb begin
    lsum        = {1'b0, in_data_i.step_time} + LifeHalf;
    lr          = lsum >> LifeShift;
    s1_d.px     = in_data_i.pos_x;
    s1_d.py     = in_data_i.pos_y;
    s1_d.pz     = in_data_i.pos_z;
    s1_d.vx     = in_data_i.vel_x;
    s1_d.vy     = in_data_i.vel_y;
    s1_d.vz     = in_data_i.vel_z;
    s1_d.dt     = in_data_i.step_time;
    s1_d.active = in_data_i.active_in;
    s1_d.gprod  = {16'd0, cfg_i.gravity} * {15'd0, in_data_i.step_time};
    s1_d.xprod  = 33'(in_data_i.vel_x) * $signed({1'b0, in_data_i.step_time});
    s1_d.zprod  = 33'(in_data_i.vel_z) * $signed({1'b0, in_data_i.step_time});
    s1_d.life   = in_data_i.active_in ?
                  sat16(19'(in_data_i.life_left) - $signed({2'b00, lr})) :
                  in_data_i.life_left;
  end

  // stage 2: apply gravity, move x and z
  always_comb begin
    gsum  = {1'b0, s1_q.gprod} + 32'd32768;
    gr    = gsum[31:16];
    xsum2 = 34'(s1_q.xprod) + 34'sd32768;
    zsum2 = 34'(s1_q.zprod) + 34'sd32768;
    xr2   = xsum2[33:16];
    zr2   = zsum2[33:16];
    s2_d.py     = s1_q.py;
    s2_d.vx     = s1_q.vx;
    s2_d.vz     = s1_q.vz;
    s2_d.life   = s1_q.life;
    s2_d.dt     = s1_q.dt;
    s2_d.active = s1_q.active;
    if (s1_q.active) begin
      s2_d.vy = sat16(19'(s1_q.vy) - $signed({3'b000, gr}));
      s2_d.px = sat16(19'(s1_q.px) + 19'(xr2));
      s2_d.pz = sat16(19'(s1_q.pz) + 19'(zr2));
    end else begin
      s2_d.vy = s1_q.vy;
      s2_d.px = s1_q.px;
      s2_d.pz = s1_q.pz;
    end
  end

  // stage 3: vertical travel, bounce and glide products
  always_comb begin
    negvy       = -17'(s2_q.vy);
    s3_d.px     = s2_q.px;
    s3_d.py     = s2_q.py;
    s3_d.pz     = s2_q.pz;
    s3_d.vx     = s2_q.vx;
    s3_d.vy     = s2_q.vy;
    s3_d.vz     = s2_q.vz;
    s3_d.life   = s2_q.life;
    s3_d.active = s2_q.active;
    s3_d.yprod  = 33'(s2_q.vy) * $signed({1'b0, s2_q.dt});
    s3_d.bprod  = 26'(negvy) * $signed({1'b0, cfg_i.bounce_gain});
    s3_d.xg     = 25'(s2_q.vx) * $signed({1'b0, cfg_i.glide_gain});
    s3_d.zg     = 25'(s2_q.vz) * $signed({1'b0, cfg_i.glide_gain});
  end

  // stage 4: move y, floor test, bounce and glide rounding, rest test
  always_comb begin
    ysum     = s3_q.yprod + 33'sd32768;
    yr       = ysum[32:16];
    py4      = sat16(19'(s3_q.py) + 19'(yr));
    bsum     = s3_q.bprod + 26'sd128;
    br       = bsum[25:8];
    vyb      = sat16(19'(br));
    xgs      = s3_q.xg + 25'sd128;
    zgs      = s3_q.zg + 25'sd128;
    xgr      = xgs[24:8];
    zgr      = zgs[24:8];
    vxb      = sat16(19'(xgr));
    vzb      = sat16(19'(zgr));
    vyb_mag  = vyb[15] ? -17'(vyb) : 17'(vyb);
    on_floor = s3_q.active && (py4 <= cfg_i.floor_level);
    at_rest  = vyb_mag < $signed({2'b00, cfg_i.rest_threshold});

    s4_d.px     = s3_q.px;
    s4_d.pz     = s3_q.pz;
    s4_d.life   = s3_q.life;
    s4_d.active = s3_q.active;
    s4_d.dmp    = on_floor && at_rest;
    if (!s3_q.active) begin
      s4_d.py = s3_q.py;
      s4_d.vx = s3_q.vx;
      s4_d.vy = s3_q.vy;
      s4_d.vz = s3_q.vz;
    end else if (on_floor) begin
      s4_d.py = cfg_i.floor_level;
      s4_d.vx = vxb;
      s4_d.vy = at_rest ? 16'sd0 : vyb;
      s4_d.vz = vzb;
    end else begin
      s4_d.py = py4;
      s4_d.vx = s3_q.vx;
      s4_d.vy = s3_q.vy;
      s4_d.vz = s3_q.vz;
    end
  end

  // stage 5: rest damping products, alive test
  always_comb begin
    s5_d.px    = s4_q.px;
    s5_d.py    = s4_q.py;
    s5_d.pz    = s4_q.pz;
    s5_d.vx    = s4_q.vx;
    s5_d.vy    = s4_q.vy;
    s5_d.vz    = s4_q.vz;
    s5_d.life  = s4_q.life;
    s5_d.dmp   = s4_q.dmp;
    s5_d.xd    = 25'(s4_q.vx) * $signed({1'b0, cfg_i.rest_damping});
    s5_d.zd    = 25'(s4_q.vz) * $signed({1'b0, cfg_i.rest_damping});
    s5_d.alive = s4_q.active && (s4_q.life > 16'sd0) &&
                 !(s4_q.py < cfg_i.lower_bound) && !(s4_q.py > cfg_i.upper_bound);
  end

  // stage 6: rest damping rounding, output word
  always_comb begin
    xds = s5_q.xd + 25'sd128;
    zds = s5_q.zd + 25'sd128;
    xdr = xds[24:8];
    zdr = zds[24:8];
    s6_d.new_pos_x = s5_q.px;
    s6_d.new_pos_y = s5_q.py;
    s6_d.new_pos_z = s5_q.pz;
    s6_d.new_vel_y = s5_q.vy;
    s6_d.new_life  = s5_q.life;
    s6_d.alive     = s5_q.alive;
    s6_d.new_vel_x = s5_q.dmp ? sat16(19'(xdr)) : s5_q.vx;
    s6_d.new_vel_z = s5_q.dmp ? sat16(19'(zdr)) : s5_q.vz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) s1_q <= s1_d;
    if (en[1]) s2_q <= s2_d;
    if (en[2]) s3_q <= s3_d;
    if (en[3]) s4_q <= s4_d;
    if (en[4]) s5_q <= s5_d;
    if (en[5]) s6_q <= s6_d;
  end

endmodule

### rtl/particle_gravity_bounce_step.sv
// Throughput: one particle per cycle while the output is not stalled; six register
// stages, each gives way when it is empty or the stage after it moves, so bubbles
// fill under backpressure.
// Reset: asynchronous, active low; clears every stage valid bit and loads
// the configuration registers with their default values.
module particle_gravity_bounce_step #(
  parameter int unsigned FRAC_BITS = pgb_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pgb_in_if.sink                       in_i,
  pgb_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [pgb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pgb_pkg::CfgDataW-1:0] cfg_data_i
);
  import pgb_pkg::*;

  cfg_t cfg_q;
  in_t  in_data;
  out_t out_data;
  logic in_ready, out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        RegGravity:       cfg_q.gravity        <= cfg_data_i[14:0];
        RegFloorLevel:    cfg_q.floor_level    <= $signed(cfg_data_i);
        RegBounceGain:    cfg_q.bounce_gain    <= cfg_data_i[7:0];
        RegGlideGain:     cfg_q.glide_gain     <= cfg_data_i[7:0];
        RegRestThreshold: cfg_q.rest_threshold <= cfg_data_i[14:0];
        RegRestDamping:   cfg_q.rest_damping   <= cfg_data_i[7:0];
        RegLowerBound:    cfg_q.lower_bound    <= $signed(cfg_data_i);
        RegUpperBound:    cfg_q.upper_bound    <= $signed(cfg_data_i);
        default:          cfg_q                <= cfg_q;
      endcase
    end
  end

  assign in_data = '{
    pos_x:     in_i.pos_x,
    pos_y:     in_i.pos_y,
    pos_z:     in_i.pos_z,
    vel_x:     in_i.vel_x,
    vel_y:     in_i.vel_y,
    vel_z:     in_i.vel_z,
    life_left: in_i.life_left,
    step_time: in_i.step_time,
    active_in: in_i.active_in
  };

  pgb_pipe #(
    .FRAC_BITS(FRAC_BITS)
  ) u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_o.ready),
    .out_data_o (out_data)
  );

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid;
  assign out_o.new_pos_x = out_data.new_pos_x;
  assign out_o.new_pos_y = out_data.new_pos_y;
  assign out_o.new_pos_z = out_data.new_pos_z;
  assign out_o.new_vel_x = out_data.new_vel_x;
  assign out_o.new_vel_y = out_data.new_vel_y;
  assign out_o.new_vel_z = out_data.new_vel_z;
  assign out_o.new_life  = out_data.new_life;
  assign out_o.alive     = out_data.alive;

endmodule

### rtl/pgb_checker.sv
`include "particle_gravity_bounce_step_defines.svh"

module pgb_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               out_alive_i,
  input logic signed [15:0] out_new_life_i
);

  `PGB_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "output word dropped while stalled")
  `PGB_ASSERT_IMP(a_in_stall, clk_i, rst_ni, !in_ready_i, out_valid_i && !out_ready_i, "input stalled with no output backpressure")
  `PGB_ASSERT_IMP(a_alive_life, clk_i, rst_ni, out_valid_i && out_alive_i, out_new_life_i > 16'sd0, "alive particle with no life left")

endmodule

bind particle_gravity_bounce_step pgb_checker u_pgb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_alive_i   (out_o.alive),
  .out_new_life_i(out_o.new_life)
);
